@@ hw/rtl/timer_min_heap_queue_core_assert.svh @@
// Assertion macros for the timer heap queue core.
// Used by timer_min_heap_queue_core.sv; no other dependencies.
`ifndef TIMER_MIN_HEAP_QUEUE_CORE_ASSERT_SVH
`define TIMER_MIN_HEAP_QUEUE_CORE_ASSERT_SVH
`ifndef SYNTH
`define TMHQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer heap queue: implication check failed");
`define TMHQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer heap queue: next-cycle check failed");
`else
`define TMHQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define TMHQ_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/tmhq_pkg.sv @@
// Types, codes and the heap order function for the timer heap queue.
// No dependencies.
package tmhq_pkg;

   localparam int MAX_RESULTS = 32;

   localparam logic [1:0] FN_ADD     = 2'd0;
   localparam logic [1:0] FN_CANCEL  = 2'd1;
   localparam logic [1:0] FN_COLLECT = 2'd2;
   localparam logic [1:0] FN_ALL     = 2'd3;

   localparam logic [2:0] KIND_ADD     = 3'd0;
   localparam logic [2:0] KIND_CANCEL  = 3'd1;
   localparam logic [2:0] KIND_DUE     = 3'd2;
   localparam logic [2:0] KIND_FLUSHED = 3'd3;
   localparam logic [2:0] KIND_NONE    = 3'd4;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] time_value;
      logic [31:0] payload_tag;
      logic [63:0] cancel_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [63:0] entry_id;
      logic [63:0] entry_wake;
      logic [31:0] payload_out;
      logic        at_top;
      logic        cancel_found;
      logic        status;
      logic        last;
      logic [5:0]  entry_count;
      logic        earliest_valid;
      logic [63:0] earliest_time;
   } rsp_type;

   // one heap slot
   typedef struct packed {
      logic [63:0] wake;
      logic [63:0] seq;
      logic [63:0] id;
      logic [31:0] payload;
   } entry_type;

   // one buffered result, before the final count and top are known
   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] id;
      logic [63:0] wake;
      logic [31:0] payload;
      logic        became;
      logic        found;
      logic        status;
   } rbuf_type;

   // heap order: earlier wake time first, then lower sequence number
   function automatic logic earlier(input entry_type a, input entry_type b);
      logic res;
      if (a.wake != b.wake) res = (a.wake < b.wake);
      else res = (a.seq < b.seq);
      return res;
   endfunction

endpackage

@@ hw/rtl/timer_min_heap_queue_core.sv @@
// Timer queue core: binary min-heap of timers in a two-read-port slot memory.
// Depends on tmhq_pkg and timer_min_heap_queue_core_assert.svh.
//
//  channel | ports                  | handshake
//  --------+------------------------+----------------------------------------
//  request | start, busy, req_data  | beat taken when start=1 and busy=0
//  result  | rsp_valid, rsp_data    | beat shown one cycle, always taken
//
// Add climbs the heap one level at a time, each level a read state then a
// compare state; cancel scans stored ids one slot at a time, then sifts the
// moved entry down and up; collect and cancel-all pop due entries one at a
// time. Slot memory reads are registered, hence a read and a compare per level.
// Results are buffered and then delivered one beat per cycle.
// Reset clears the count and the id and sequence counters; slots need no clear.
// The receiver cannot stall; busy stays high until the last beat is issued.
`include "timer_min_heap_queue_core_assert.svh"
module timer_min_heap_queue_core #(
   parameter int CAPACITY = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tmhq_pkg::req_type req_data,
   output logic             rsp_valid,
   output tmhq_pkg::rsp_type rsp_data
);
   import tmhq_pkg::*;

   localparam int AW  = $clog2(CAPACITY);
   localparam int IW  = AW + 2;
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int RBW = $clog2(MAX_RESULTS);
   localparam int RCW = $clog2(MAX_RESULTS + 1);

   typedef enum logic [12:0] {
      ST_IDLE     = 13'b0000000000001,
      ST_ADD      = 13'b0000000000010,
      ST_CAN_SCAN = 13'b0000000000100,
      ST_CAN_CMP  = 13'b0000000001000,
      ST_COL      = 13'b0000000010000,
      ST_RM_LOAD  = 13'b0000000100000,
      ST_SD_RD    = 13'b0000001000000,
      ST_SD_CMP   = 13'b0000010000000,
      ST_SU_RD    = 13'b0000100000000,
      ST_SU_CMP   = 13'b0001000000000,
      ST_FIN      = 13'b0010000000000,
      ST_EMIT_RD  = 13'b0100000000000,
      ST_EMIT     = 13'b1000000000000
   } state_type;

   // slot memory and result buffer
   entry_type heap_mem [CAPACITY];
   rbuf_type  rbuf_mem [MAX_RESULTS];

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [63:0]      next_id_ff, next_id_in;
   logic [63:0]      next_seq_ff, next_seq_in;
   entry_type        e_ff, e_in;
   logic [AW-1:0]    i_ff, i_in;
   logic [AW-1:0]    start_i_ff, start_i_in;
   logic [CW-1:0]    scan_ff, scan_in;
   logic [RCW-1:0]   n_ff, n_in;
   logic [RBW-1:0]   k_ff, k_in;
   logic [63:0]      add_id_ff, add_id_in;
   entry_type        top_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   entry_type        mem_wdata;
   logic [AW-1:0]    rd_a, rd_b;
   entry_type        mem_qa, mem_qb;
   logic             rb_we;
   logic [RBW-1:0]   rb_waddr, rb_raddr;
   rbuf_type         rb_wdata, rb_q;

   logic [CW-1:0]    lastpos;
   logic [IW-1:0]    lidx, ridx;
   logic [AW-1:0]    parent;
   logic             due;
   logic             moved;
   entry_type        best_ent;
   logic [IW-1:0]    best_idx;

   always_ff @(posedge clock) begin
      if (mem_we) heap_mem[mem_waddr] <= mem_wdata;
      mem_qa <= heap_mem[rd_a];
      mem_qb <= heap_mem[rd_b];
   end

   always_ff @(posedge clock) begin
      if (rb_we) rbuf_mem[rb_waddr] <= rb_wdata;
      rb_q <= rbuf_mem[rb_raddr];
   end

   // mirror slot 0 for the top-of-heap fields
   always_ff @(posedge clock) begin
      if (mem_we && mem_waddr == '0) top_ff <= mem_wdata;
   end

   always_comb begin
      lastpos = count_ff - 1'b1;
      lidx    = (IW'(i_ff) << 1) + IW'(1);
      ridx    = (IW'(i_ff) << 1) + IW'(2);
      parent  = (i_ff - 1'b1) >> 1;
      due     = (count_ff != '0) && (n_ff < RCW'(MAX_RESULTS)) &&
                ((req_ff.func == FN_ALL) || (top_ff.wake <= req_ff.time_value));
      best_ent = e_ff;
      best_idx = IW'(i_ff);
      moved    = 1'b0;
      if (earlier(mem_qa, e_ff)) begin
         best_ent = mem_qa;
         best_idx = lidx;
         moved    = 1'b1;
      end
      if ((ridx < IW'(count_ff)) && earlier(mem_qb, best_ent)) begin
         best_ent = mem_qb;
         best_idx = ridx;
         moved    = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      next_id_in   = next_id_ff;
      next_seq_in  = next_seq_ff;
      e_in         = e_ff;
      i_in         = i_ff;
      start_i_in   = start_i_ff;
      scan_in      = scan_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      add_id_in    = add_id_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = i_ff;
      mem_wdata    = e_ff;
      rd_a         = '0;
      rd_b         = '0;
      rb_we        = 1'b0;
      rb_waddr     = '0;
      rb_wdata     = '0;
      rb_raddr     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               n_in   = '0;
               scan_in = '0;
               case (req_data.func)
                  FN_ADD:    state_in = ST_ADD;
                  FN_CANCEL: state_in = ST_CAN_SCAN;
                  default:   state_in = ST_COL;
               endcase
            end
         end
         ST_ADD: begin
            if (count_ff >= CW'(CAPACITY)) begin
               // full: reject without consuming an id
               rb_we           = 1'b1;
               rb_wdata.kind   = KIND_ADD;
               rb_wdata.status = 1'b1;
               n_in            = RCW'(1);
               state_in        = ST_EMIT_RD;
            end else begin
               e_in.wake    = req_ff.time_value;
               e_in.seq     = next_seq_ff;
               e_in.id      = next_id_ff;
               e_in.payload = req_ff.payload_tag;
               add_id_in    = next_id_ff;
               next_id_in   = next_id_ff + 64'd1;
               next_seq_in  = next_seq_ff + 64'd1;
               i_in         = count_ff[AW-1:0];
               start_i_in   = count_ff[AW-1:0];
               count_in     = count_ff + 1'b1;
               state_in     = ST_SU_RD;
            end
         end
         ST_CAN_SCAN: begin
            if (scan_ff >= count_ff) begin
               rb_we         = 1'b1;
               rb_wdata.kind = KIND_CANCEL;
               rb_wdata.id   = req_ff.cancel_id;
               n_in          = RCW'(1);
               state_in      = ST_EMIT_RD;
            end else begin
               rd_a     = scan_ff[AW-1:0];
               state_in = ST_CAN_CMP;
            end
         end
         ST_CAN_CMP: begin
            if (mem_qa.id == req_ff.cancel_id) begin
               rb_we            = 1'b1;
               rb_wdata.kind    = KIND_CANCEL;
               rb_wdata.id      = req_ff.cancel_id;
               rb_wdata.wake    = mem_qa.wake;
               rb_wdata.payload = mem_qa.payload;
               rb_wdata.found   = 1'b1;
               n_in             = RCW'(1);
               count_in         = lastpos;
               if (scan_ff != lastpos) begin
                  // pull the last entry into the hole
                  rd_a       = lastpos[AW-1:0];
                  i_in       = scan_ff[AW-1:0];
                  start_i_in = scan_ff[AW-1:0];
                  state_in   = ST_RM_LOAD;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = ST_CAN_SCAN;
            end
         end
         ST_COL: begin
            if (due) begin
               rb_we            = 1'b1;
               rb_waddr         = n_ff[RBW-1:0];
               rb_wdata.kind    = (req_ff.func == FN_ALL) ? KIND_FLUSHED : KIND_DUE;
               rb_wdata.id      = top_ff.id;
               rb_wdata.wake    = top_ff.wake;
               rb_wdata.payload = top_ff.payload;
               n_in             = n_ff + 1'b1;
               count_in         = lastpos;
               if (lastpos != '0) begin
                  rd_a       = lastpos[AW-1:0];
                  i_in       = '0;
                  start_i_in = '0;
                  state_in   = ST_RM_LOAD;
               end
            end else if (n_ff == '0) begin
               rb_we         = 1'b1;
               rb_wdata.kind = KIND_NONE;
               n_in          = RCW'(1);
               state_in      = ST_EMIT_RD;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_RM_LOAD: begin
            e_in     = mem_qa;
            state_in = ST_SD_RD;
         end
         ST_SD_RD: begin
            if (lidx >= IW'(count_ff)) begin
               if (i_ff == start_i_ff) begin
                  state_in = ST_SU_RD;
               end else begin
                  mem_we   = 1'b1;
                  state_in = ST_FIN;
               end
            end else begin
               rd_a     = lidx[AW-1:0];
               rd_b     = ridx[AW-1:0];
               state_in = ST_SD_CMP;
            end
         end
         ST_SD_CMP: begin
            if (moved) begin
               // move the earlier child up into the hole
               mem_we    = 1'b1;
               mem_wdata = best_ent;
               i_in      = best_idx[AW-1:0];
               state_in  = ST_SD_RD;
            end else if (i_ff == start_i_ff) begin
               state_in = ST_SU_RD;
            end else begin
               mem_we   = 1'b1;
               state_in = ST_FIN;
            end
         end
         ST_SU_RD: begin
            if (i_ff == '0) begin
               mem_we   = 1'b1;
               state_in = ST_FIN;
            end else begin
               rd_a     = parent;
               state_in = ST_SU_CMP;
            end
         end
         ST_SU_CMP: begin
            if (earlier(e_ff, mem_qa)) begin
               mem_we    = 1'b1;
               mem_wdata = mem_qa;
               i_in      = parent;
               state_in  = ST_SU_RD;
            end else begin
               mem_we   = 1'b1;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            case (req_ff.func)
               FN_ADD: begin
                  rb_we            = 1'b1;
                  rb_wdata.kind    = KIND_ADD;
                  rb_wdata.id      = add_id_ff;
                  rb_wdata.wake    = e_ff.wake;
                  rb_wdata.payload = e_ff.payload;
                  rb_wdata.became  = (top_ff.id == add_id_ff);
                  n_in             = RCW'(1);
                  state_in         = ST_EMIT_RD;
               end
               FN_CANCEL: state_in = ST_EMIT_RD;
               default:   state_in = ST_COL;
            endcase
         end
         ST_EMIT_RD: begin
            rb_raddr = '0;
            k_in     = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid_in           = 1'b1;
            rsp_in.result_kind     = rb_q.kind;
            rsp_in.entry_id        = rb_q.id;
            rsp_in.entry_wake      = rb_q.wake;
            rsp_in.payload_out     = rb_q.payload;
            rsp_in.at_top          = rb_q.became;
            rsp_in.cancel_found    = rb_q.found;
            rsp_in.status          = rb_q.status;
            rsp_in.last            = (RCW'(k_ff) == n_ff - 1'b1);
            rsp_in.entry_count     = 6'(count_ff);
            rsp_in.earliest_valid  = (count_ff != '0);
            rsp_in.earliest_time   = (count_ff != '0) ? top_ff.wake : 64'd0;
            if (RCW'(k_ff) == n_ff - 1'b1) begin
               state_in = ST_IDLE;
            end else begin
               k_in     = k_ff + 1'b1;
               rb_raddr = k_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         next_id_ff   <= '0;
         next_seq_ff  <= '0;
         n_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_id_ff   <= next_id_in;
         next_seq_ff  <= next_seq_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      e_ff       <= e_in;
      i_ff       <= i_in;
      start_i_ff <= start_i_in;
      scan_ff    <= scan_in;
      add_id_ff  <= add_id_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `TMHQ_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `TMHQ_ASSERT_IMP(a_results_bound, clock, reset, 1'b1, n_ff <= RCW'(MAX_RESULTS))
   `TMHQ_ASSERT_NXT(a_accept_leaves_idle, clock, reset, start && !busy, state_ff != ST_IDLE)
   `TMHQ_ASSERT_IMP(a_emit_in_range, clock, reset, state_ff == ST_EMIT, RCW'(k_ff) < n_ff)

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for timer_min_heap_queue_core: a shadow heap predicts every beat.
// Depends on tmhq_pkg and the core RTL only.
module tb_top;
   import tmhq_pkg::*;

   localparam int CAP = 32;
   localparam int CYCLE_LIMIT = 2000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   timer_min_heap_queue_core #(.CAPACITY(CAP)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // shadow heap state
   entry_type shadow_slot [CAP];
   int        shadow_count;
   logic [63:0] shadow_next_id;
   logic [63:0] shadow_next_seq;

   rsp_type pending_beats [$];
   int      mismatch_count;
   int      send_idle_pct;
   int      cycle_count;

   // heap order: earlier wake first, then older sequence
   function automatic bit ahead(entry_type a, entry_type b);
      if (a.wake != b.wake) return a.wake < b.wake;
      return a.seq < b.seq;
   endfunction

   function automatic void swap_entries(int a, int b);
      entry_type t;
      t = shadow_slot[a];
      shadow_slot[a] = shadow_slot[b];
      shadow_slot[b] = t;
   endfunction

   function automatic void climb(int i);
      int p;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!ahead(shadow_slot[i], shadow_slot[p])) break;
         swap_entries(i, p);
         i = p;
      end
   endfunction

   function automatic void sink(int i);
      int best, l, r;
      forever begin
         best = i;
         l = 2 * i + 1;
         r = 2 * i + 2;
         if (l < shadow_count && ahead(shadow_slot[l], shadow_slot[best])) best = l;
         if (r < shadow_count && ahead(shadow_slot[r], shadow_slot[best])) best = r;
         if (best == i) break;
         swap_entries(i, best);
         i = best;
      end
   endfunction

   function automatic void evict(int i);
      shadow_count--;
      if (i != shadow_count) begin
         shadow_slot[i] = shadow_slot[shadow_count];
         sink(i);
         climb(i);
      end
   endfunction

   // compute the beats one request causes and queue them
   function automatic void predict_beats(req_type rq);
      rsp_type   b [$];
      rsp_type   r;
      entry_type e;
      b = {};
      r = '0;
      case (rq.func)
         FN_ADD: begin
            r.result_kind = KIND_ADD;
            if (shadow_count >= CAP) begin
               r.status = 1'b1;
            end else begin
               e.wake = rq.time_value;
               e.seq = shadow_next_seq;
               e.id = shadow_next_id;
               e.payload = rq.payload_tag;
               shadow_next_id++;
               shadow_next_seq++;
               shadow_slot[shadow_count] = e;
               shadow_count++;
               climb(shadow_count - 1);
               r.entry_id = e.id;
               r.entry_wake = e.wake;
               r.payload_out = e.payload;
               r.at_top = (shadow_slot[0].id == e.id);
            end
            b = {b, r};
         end
         FN_CANCEL: begin
            r.result_kind = KIND_CANCEL;
            r.entry_id = rq.cancel_id;
            for (int i = 0; i < shadow_count; i++) begin
               if (shadow_slot[i].id == rq.cancel_id) begin
                  r.entry_wake = shadow_slot[i].wake;
                  r.payload_out = shadow_slot[i].payload;
                  r.cancel_found = 1'b1;
                  evict(i);
                  break;
               end
            end
            b = {b, r};
         end
         default: begin
            while (shadow_count > 0 && b.size() < MAX_RESULTS &&
                   (rq.func == FN_ALL || shadow_slot[0].wake <= rq.time_value)) begin
               r = '0;
               r.result_kind = (rq.func == FN_COLLECT) ? KIND_DUE : KIND_FLUSHED;
               r.entry_id = shadow_slot[0].id;
               r.entry_wake = shadow_slot[0].wake;
               r.payload_out = shadow_slot[0].payload;
               b = {b, r};
               evict(0);
            end
            if (b.size() == 0) begin
               r = '0;
               r.result_kind = KIND_NONE;
               b = {b, r};
            end
         end
      endcase
      // count and top reflect the state after the whole request
      foreach (b[k]) begin
         b[k].last = (k == b.size() - 1);
         b[k].entry_count = shadow_count[5:0];
         b[k].earliest_valid = (shadow_count > 0);
         b[k].earliest_time = (shadow_count > 0) ? shadow_slot[0].wake : 64'd0;
         pending_beats = {pending_beats, b[k]};
      end
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // check every result beat against the oldest prediction
   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_valid) begin
         if (pending_beats.size() == 0) begin
            report_mismatch("unexpected beat kind", 64'(rsp_data.result_kind), 64'd0);
         end else begin
            w = pending_beats.pop_front();
            if (rsp_data.result_kind != w.result_kind)
               report_mismatch("result_kind", 64'(rsp_data.result_kind),
                               64'(w.result_kind));
            if (rsp_data.entry_id != w.entry_id)
               report_mismatch("entry_id", rsp_data.entry_id, w.entry_id);
            if (rsp_data.entry_wake != w.entry_wake)
               report_mismatch("entry_wake", rsp_data.entry_wake, w.entry_wake);
            if (rsp_data.payload_out != w.payload_out)
               report_mismatch("payload_out", 64'(rsp_data.payload_out),
                               64'(w.payload_out));
            if (rsp_data.at_top != w.at_top)
               report_mismatch("at_top", 64'(rsp_data.at_top), 64'(w.at_top));
            if (rsp_data.cancel_found != w.cancel_found)
               report_mismatch("cancel_found", 64'(rsp_data.cancel_found),
                               64'(w.cancel_found));
            if (rsp_data.status != w.status)
               report_mismatch("status", 64'(rsp_data.status), 64'(w.status));
            if (rsp_data.last != w.last)
               report_mismatch("last", 64'(rsp_data.last), 64'(w.last));
            if (rsp_data.entry_count != w.entry_count)
               report_mismatch("entry_count", 64'(rsp_data.entry_count),
                               64'(w.entry_count));
            if (rsp_data.earliest_valid != w.earliest_valid)
               report_mismatch("earliest_valid", 64'(rsp_data.earliest_valid),
                               64'(w.earliest_valid));
            if (rsp_data.earliest_time != w.earliest_time)
               report_mismatch("earliest_time", rsp_data.earliest_time, w.earliest_time);
         end
      end
   end

   // watchdog: end the run if the core hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timer_min_heap_queue_core regression: fail");
         $finish;
      end
   end

   // drive one beat at a falling edge; optionally idle first, hold start until
   // the core takes it, and return at the accepting edge
   task automatic send_beat(logic [1:0] fn, logic [63:0] tv, logic [31:0] tag,
                            logic [63:0] cid);
      req_type rq;
      rq.func = fn;
      rq.time_value = tv;
      rq.payload_tag = tag;
      rq.cancel_id = cid;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_beats(rq);
   endtask

   task automatic drain_wait();
      start <= 1'b0;
      while (pending_beats.size() != 0) @(negedge clock);
   endtask

   // a wake time picked to collide often, with occasional extremes
   function automatic logic [63:0] pick_wake();
      case ($urandom_range(9))
         0: return 64'd0;
         1: return '1;
         2: return {$urandom, $urandom};
         default: return 64'($urandom_range(200));
      endcase
   endfunction

   function automatic logic [63:0] pick_cancel_id();
      if (shadow_count > 0 && $urandom_range(3) != 0)
         return shadow_slot[$urandom_range(shadow_count - 1)].id;
      if ($urandom_range(1)) return {$urandom, $urandom};
      return shadow_next_id + 64'($urandom_range(3));
   endfunction

   task automatic test_directed_edges();
      // extremes, ties, absent cancel, empty pops
      send_beat(FN_COLLECT, '1, 32'h0, 64'h0);
      send_beat(FN_ALL, 64'h0, '1, '1);
      send_beat(FN_CANCEL, 64'h0, 32'h0, 64'h5);
      send_beat(FN_ADD, '1, '1, '1);
      send_beat(FN_ADD, 64'h0, 32'h0, 64'h0);
      send_beat(FN_ADD, 64'h10, 32'hA5A5_5A5A, 64'h0);
      send_beat(FN_ADD, 64'h10, 32'h5A5A_A5A5, 64'h0);
      send_beat(FN_ADD, 64'h8, 32'h1234_5678, 64'h0);
      send_beat(FN_CANCEL, 64'h0, 32'h0, 64'd2);
      send_beat(FN_CANCEL, 64'h0, 32'h0, 64'd2);
      send_beat(FN_CANCEL, 64'h0, 32'h0, '1);
      send_beat(FN_COLLECT, 64'h0, 32'h0, 64'h0);
      send_beat(FN_COLLECT, 64'h10, 32'h0, 64'h0);
      send_beat(FN_COLLECT, 64'hF, 32'h0, 64'h0);
      send_beat(FN_ALL, 64'h0, 32'h0, 64'h0);
      drain_wait();
   endtask

   task automatic test_full_heap();
      // fill past capacity, cancel and refill the last slot, then collect and flush
      for (int i = 0; i < CAP + 2; i++)
         send_beat(FN_ADD, 64'($urandom_range(40)), $urandom, 64'h0);
      send_beat(FN_CANCEL, 64'h0, 32'h0, shadow_slot[CAP - 1].id);
      send_beat(FN_ADD, '1, $urandom, 64'h0);
      send_beat(FN_COLLECT, 64'd20, 32'h0, 64'h0);
      send_beat(FN_ALL, 64'h0, 32'h0, 64'h0);
      drain_wait();
   endtask

   task automatic test_random_mix(int n_beats);
      logic [1:0] fn;
      for (int i = 0; i < n_beats; i++) begin
         // mostly adds and cancels to keep the heap populated
         case ($urandom_range(9))
            0, 1, 2, 3, 4: fn = FN_ADD;
            5, 6: fn = FN_CANCEL;
            7, 8: fn = FN_COLLECT;
            default: fn = ($urandom_range(3) == 0) ? FN_ALL : FN_COLLECT;
         endcase
         send_beat(fn, (fn == FN_COLLECT) ? 64'($urandom_range(250)) : pick_wake(),
                   $urandom, pick_cancel_id());
         if (i == n_beats / 2) drain_wait();
      end
      drain_wait();
   endtask

   initial begin
      mismatch_count = 0;
      cycle_count = 0;
      shadow_count = 0;
      shadow_next_id = '0;
      shadow_next_seq = '0;
      send_idle_pct = 28;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_edges();
      test_full_heap();
      test_random_mix(130);
      send_idle_pct = 47;
      test_random_mix(130);
      send_idle_pct = 0;
      test_random_mix(130);

      drain_wait();
      repeat (200) @(negedge clock);
      if (mismatch_count == 0 && pending_beats.size() == 0) begin
         $display("timer_min_heap_queue_core regression: pass");
      end else begin
         $display("timer_min_heap_queue_core regression: fail");
      end
      $finish;
   end

endmodule
